### rtl/pixel_affinity_edge_min_macros.svh
// assertion macros shared by the pixel affinity edge block
// expects clk and rst_n in the scope of every use
`ifndef PIXEL_AFFINITY_EDGE_MIN_MACROS_SVH
`define PIXEL_AFFINITY_EDGE_MIN_MACROS_SVH

// same-cycle implication, checked outside reset
`define PAE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pae_pkg.sv
// shared types and constants of the pixel affinity edge block
// no dependencies
package pae_pkg;

  localparam int CFG_W      = 11;   // configuration data bits
  localparam int CFG_IDX_W  = 2;    // register index bits
  localparam int ROW_W      = 10;   // row counter and edge_row bits
  localparam int COL_OUT_W  = 10;   // edge_col bits
  localparam int MAX_HEIGHT = 1024;
  localparam int QDEPTH     = 4;    // front-to-back queue entries
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // configuration write as seen by the front
  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  // queue fill status
  typedef struct packed {
    logic [QCNT_W-1:0] level;
    logic              empty;
  } q_status_t;

endpackage

### rtl/pae_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module pae_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/pae_front.sv
// front of the pixel affinity edge block: frame size, raster counters,
// line store and gathering of centre, right and below words; uses pae_pkg, pae_ram
`include "pixel_affinity_edge_min_macros.svh"
module pae_front #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int ENTRY_W     = 3 * 16 + 21
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pae_pkg::cfg_wr_t       cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  pae_pkg::q_status_t     q_stat,
  output logic                   q_push,
  output logic [ENTRY_W-1:0]     q_din
);
  import pae_pkg::*;

  localparam int MAXW_EFF = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
  localparam int CW       = $clog2(MAXW_EFF + 1);
  localparam int AW       = $clog2(MAX_WIDTH);
  localparam int RST_W    = (MAXW_EFF < 1024) ? MAXW_EFF : 1024;

  logic [CW-1:0]          w_r, w_nxt;
  logic [CFG_W-1:0]       h_r, h_nxt;
  logic [CW-1:0]          col_r, col_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [SAMPLE_BITS-1:0] row0_r;
  logic [SAMPLE_BITS-1:0] prev_right_r;

  logic                   s1_v_r;
  logic                   s1_edge_r;
  logic                   s1_first_r;
  logic [SAMPLE_BITS-1:0] s1_c0_r;
  logic [SAMPLE_BITS-1:0] s1_below_r;
  logic [ROW_W-1:0]       s1_row_r;
  logic [COL_OUT_W-1:0]   s1_col_r;
  logic                   s1_done_r;

  logic                   in_fire;
  logic [CW:0]            col_p1, col_p2, w_ext;
  logic [CFG_W-1:0]       row_p1;
  logic                   is_edge, is_done;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [SAMPLE_BITS-1:0] center;

  // room for the word in flight plus the one being accepted
  assign in_ready = (q_stat.level + QCNT_W'(s1_v_r)) < QCNT_W'(QDEPTH);
  assign in_fire  = in_valid && in_ready;

  assign w_ext  = {1'b0, w_r};
  assign col_p1 = {1'b0, col_r} + (CW + 1)'(1);
  assign col_p2 = {1'b0, col_r} + (CW + 1)'(2);
  assign row_p1 = {1'b0, row_r} + CFG_W'(1);

  assign is_edge = (row_r != '0) && (col_p1 < w_ext);
  assign is_done = (row_p1 == h_r) && (col_p2 == w_ext);

  always_comb begin
    w_nxt   = w_r;
    h_nxt   = h_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg.we && (cfg.index == REG_FRAME_WIDTH || cfg.index == REG_FRAME_HEIGHT)) begin
      col_nxt = '0;
      row_nxt = '0;
      if (cfg.index == REG_FRAME_WIDTH) begin
        if (cfg.data < CFG_W'(2)) begin
          w_nxt = CW'(2);
        end else if (cfg.data > CFG_W'(MAXW_EFF)) begin
          w_nxt = CW'(MAXW_EFF);
        end else begin
          w_nxt = CW'(cfg.data);
        end
      end else begin
        if (cfg.data < CFG_W'(2)) begin
          h_nxt = CFG_W'(2);
        end else if (cfg.data > CFG_W'(MAX_HEIGHT)) begin
          h_nxt = CFG_W'(MAX_HEIGHT);
        end else begin
          h_nxt = cfg.data;
        end
      end
    end else if (in_fire) begin
      if (col_p1 >= w_ext) begin
        col_nxt = '0;
        row_nxt = (row_p1 >= h_r) ? '0 : ROW_W'(row_p1);
      end else begin
        col_nxt = CW'(col_p1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r    <= CW'(RST_W);
      h_r    <= CFG_W'(MAX_HEIGHT);
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      w_r    <= w_nxt;
      h_r    <= h_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= in_fire;
    end
  end

  // payload side, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (col_r == '0) begin
        row0_r <= in_sample;
      end
      s1_first_r <= (col_r == '0);
      s1_c0_r    <= row0_r;
      s1_edge_r  <= is_edge;
      s1_below_r <= in_sample;
      s1_row_r   <= row_r - ROW_W'(1);
      s1_col_r   <= COL_OUT_W'(col_r);
      s1_done_r  <= is_done;
    end
    if (s1_v_r) begin
      prev_right_r <= ram_rdata;
    end
  end

  // write this column, read the right neighbour from the row above
  pae_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (in_fire),
    .waddr (AW'(col_r)),
    .wdata (in_sample),
    .re    (in_fire),
    .raddr (AW'(col_p1)),
    .rdata (ram_rdata)
  );

  // centre is the previous word's right neighbour, or the saved column zero
  assign center = s1_first_r ? s1_c0_r : prev_right_r;
  assign q_push = s1_v_r && s1_edge_r;
  assign q_din  = {s1_done_r, s1_col_r, s1_row_r, ram_rdata, center, s1_below_r};

  `PAE_ASSERT_IMPL(a_col_in_range, 1'b1, col_r < w_r, "column counter beyond frame width")
  `PAE_ASSERT_IMPL(a_row_in_range, 1'b1, {1'b0, row_r} < h_r, "row counter beyond frame height")
  `PAE_ASSERT_IMPL(a_push_room, s1_v_r, q_stat.level < QCNT_W'(QDEPTH), "queue full at push")

endmodule

### rtl/pae_queue.sv
// short queue between front and back of the pixel affinity edge block
// uses pae_pkg
`include "pixel_affinity_edge_min_macros.svh"
module pae_queue #(
  parameter int WIDTH = 69
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [WIDTH-1:0]   din,
  input  logic               pop,
  output logic [WIDTH-1:0]   dout,
  output pae_pkg::q_status_t stat
);
  import pae_pkg::*;

  logic [WIDTH-1:0]  slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] level_r, level_nxt;

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + QCNT_W'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      level_r <= level_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  assign dout       = slot_r[rd_ptr_r];
  assign stat.level = level_r;
  assign stat.empty = (level_r == '0);

  `PAE_ASSERT_IMPL(a_no_overflow, push, level_r < QCNT_W'(QDEPTH), "push into full queue")
  `PAE_ASSERT_NEXT(a_level_step, push && !pop, level_r == $past(level_r) + QCNT_W'(1), "level did not step on push")

endmodule

### rtl/pae_back.sv
// back of the pixel affinity edge block: minima, pick flags and output register
// uses pae_pkg
module pae_back #(
  parameter int SAMPLE_BITS = 16,
  parameter int ENTRY_W     = 3 * 16 + 21,
  parameter int OUT_W       = 56
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [ENTRY_W-1:0] q_dout,
  input  pae_pkg::q_status_t q_stat,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata,
  output logic [1:0]         out_tuser,
  output logic               out_tlast
);
  import pae_pkg::*;

  localparam int SB = SAMPLE_BITS;

  logic signed [SB-1:0] below, center, right;
  logic [ROW_W-1:0]     e_row;
  logic [COL_OUT_W-1:0] e_col;
  logic                 e_done;
  logic                 vpick, hpick;

  logic                 out_v_r;
  logic [SB-1:0]        vmin_r, hmin_r;
  logic                 vpick_r, hpick_r;
  logic [ROW_W-1:0]     row_r;
  logic [COL_OUT_W-1:0] col_r;
  logic                 done_r;

  assign below  = q_dout[SB-1:0];
  assign center = q_dout[2*SB-1:SB];
  assign right  = q_dout[3*SB-1:2*SB];
  assign e_row  = q_dout[3*SB+ROW_W-1:3*SB];
  assign e_col  = q_dout[3*SB+ROW_W+COL_OUT_W-1:3*SB+ROW_W];
  assign e_done = q_dout[3*SB+ROW_W+COL_OUT_W];

  // ties go to the neighbour
  assign vpick = !(center < below);
  assign hpick = !(center < right);

  assign q_pop = !q_stat.empty && (!out_v_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      vmin_r  <= vpick ? below : center;
      hmin_r  <= hpick ? right : center;
      vpick_r <= vpick;
      hpick_r <= hpick;
      row_r   <= e_row;
      col_r   <= e_col;
      done_r  <= e_done;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'({col_r, row_r, hmin_r, vmin_r});
  assign out_tuser  = {hpick_r, vpick_r};
  assign out_tlast  = done_r;

endmodule

### rtl/pixel_affinity_edge_min.sv
// pixel affinity edge block, top level
// uses pae_pkg, pae_front, pae_queue, pae_back
//
// Takes one image channel in raster order, one signed fixed-point sample per
// word, and for every pixel that has both a right and a lower neighbour emits
// one word holding min(centre, below) and min(centre, right), a pick flag for
// each (0 when the centre is strictly smaller, so ties give 1), the centre's
// row and column, and tlast on the last edge of the frame. The word for a
// centre leaves once the pixel below it has arrived; the last row and column
// give no words. The block takes one sample every clock while the queue has
// room; a result passes the line store read, queue and output registers; the
// line store is one ram of MAX_WIDTH words with one write and one read port.
// Frame size is set through the configuration channel (register 0 width,
// register 1 height; height clamped to 2..1024, width to 2..MAX_WIDTH up to
// 2047; reset 1024 within those bounds); a write to either register restarts
// the frame at row 0, column 0, and must only be made while the block is idle.
module pixel_affinity_edge_min #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pae_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pae_pkg::CFG_W-1:0]            cfg_data,
  // sample input
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // in_tdata: sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  // edge output
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // out_tdata: vertical_edge, horizontal_edge, edge_row, edge_col, zero fill
  output logic [((2*SAMPLE_BITS+27)/8)*8-1:0]  out_tdata,
  // out_tuser: vertical_pick, horizontal_pick
  output logic [1:0]                           out_tuser,
  // out_tlast: frame_done
  output logic                                 out_tlast
);
  import pae_pkg::*;

  // queue word: below, centre, right, row, column, frame end
  localparam int ENTRY_W = 3 * SAMPLE_BITS + ROW_W + COL_OUT_W + 1;
  localparam int OUT_W   = ((2 * SAMPLE_BITS + ROW_W + COL_OUT_W + 7) / 8) * 8;

  cfg_wr_t            cfg;
  q_status_t          q_stat;
  logic               q_push, q_pop;
  logic [ENTRY_W-1:0] q_din, q_dout;

  // configuration is always taken; the front applies it at once
  assign cfg_ready = 1'b1;
  assign cfg.we    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // front: counters, line store and gathering of the three neighbours
  pae_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  // decouples the sample side from output back-pressure
  pae_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  // back: compare, select and hold the result word
  pae_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ENTRY_W     (ENTRY_W),
    .OUT_W       (OUT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_dout     (q_dout),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### verif/pae_edge_checker.sv
`timescale 1ns / 100ps
// edge checker for the pixel affinity edge block: mirrors the line store and raster
// counters, predicts every edge word and compares it with the output channel
// depends on pae_pkg
module pae_edge_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pae_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pae_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [15:0]                   in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [55:0]                   out_tdata,
  input  logic [1:0]                    out_tuser,
  input  logic                          out_tlast,
  output int                            mismatches,
  output int                            pending,
  output int                            edges_checked
);
  import pae_pkg::*;

  localparam int REPORT_LIMIT = 40;

  typedef struct packed {
    logic [15:0] v_min;
    logic [15:0] h_min;
    logic        v_pick;
    logic        h_pick;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        last;
  } edge_word_t;

  edge_word_t         expected_edges [$];
  logic signed [15:0] line_store [MAX_WIDTH];
  logic [CFG_W-1:0]   width_reg;
  logic [CFG_W-1:0]   height_reg;
  int                 col_next;
  int                 row_next;
  int                 fault_count;
  int                 checked_count;

  function automatic int clamp_size(input logic [CFG_W-1:0] v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    fault_count++;
    if (fault_count <= REPORT_LIMIT)
      $display("[%0t] edge word mismatch: %s got 0x%0h expected 0x%0h", $time, what, got,
               want);
  endtask

  task automatic check_edge();
    edge_word_t want;
    if (expected_edges.size() == 0) begin
      report("edge word with none outstanding, low data", out_tdata[31:0], 32'd0);
      return;
    end
    want = expected_edges.pop_front();
    checked_count++;
    if (out_tdata[15:0] !== want.v_min)
      report("vertical_edge", 32'(out_tdata[15:0]), 32'(want.v_min));
    if (out_tdata[31:16] !== want.h_min)
      report("horizontal_edge", 32'(out_tdata[31:16]), 32'(want.h_min));
    if (out_tuser[0] !== want.v_pick)
      report("vertical_pick", 32'(out_tuser[0]), 32'(want.v_pick));
    if (out_tuser[1] !== want.h_pick)
      report("horizontal_pick", 32'(out_tuser[1]), 32'(want.h_pick));
    if (out_tdata[41:32] !== want.row)
      report("edge_row", 32'(out_tdata[41:32]), 32'(want.row));
    if (out_tdata[51:42] !== want.col)
      report("edge_col", 32'(out_tdata[51:42]), 32'(want.col));
    if (out_tlast !== want.last)
      report("frame_done", 32'(out_tlast), 32'(want.last));
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    // unused indexes leave the frame running
    if (idx == REG_FRAME_WIDTH) begin
      width_reg = val;
      col_next  = 0;
      row_next  = 0;
    end else if (idx == REG_FRAME_HEIGHT) begin
      height_reg = val;
      col_next   = 0;
      row_next   = 0;
    end
  endtask

  task automatic predict_edge(input logic signed [15:0] lower);
    int                 w;
    int                 h;
    logic signed [15:0] centre;
    logic signed [15:0] right_px;
    edge_word_t         e;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    if (col_next >= w) col_next = 0;
    if (row_next >= h) row_next = 0;
    if (row_next >= 1 && col_next + 1 < w) begin
      centre   = line_store[col_next];
      right_px = line_store[col_next + 1];
      e.v_min  = (centre < lower) ? centre : lower;
      e.h_min  = (centre < right_px) ? centre : right_px;
      e.v_pick = (centre < lower) ? 1'b0 : 1'b1;
      e.h_pick = (centre < right_px) ? 1'b0 : 1'b1;
      e.row    = 10'(row_next - 1);
      e.col    = 10'(col_next);
      e.last   = (row_next + 1 == h) && (col_next + 2 == w);
      expected_edges.insert(expected_edges.size(), e);
    end
    line_store[col_next] = lower;
    col_next++;
    if (col_next >= w) begin
      col_next = 0;
      row_next++;
      if (row_next >= h) row_next = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_edges.delete();
      width_reg     = 11'd1024;
      height_reg    = 11'd1024;
      col_next      = 0;
      row_next      = 0;
      fault_count   = 0;
      checked_count = 0;
    end else begin
      if (out_tvalid && out_tready) check_edge();
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_tvalid && in_tready) predict_edge(in_tdata);
    end
    mismatches    <= fault_count;
    pending       <= expected_edges.size();
    edges_checked <= checked_count;
  end

endmodule

### verif/tb_pixel_affinity_edge_min.sv
`timescale 1ns / 100ps
// testbench top for the pixel affinity edge block: drives samples, frame sizes and
// output stalls, and gives the verdict from the edge checker
// depends on pae_pkg, pae_edge_checker and the block itself
module tb_pixel_affinity_edge_min;
  import pae_pkg::*;

  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 400000;

  // indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;   // sample
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [55:0]          out_tdata;        // vertical_edge, horizontal_edge, edge_row, edge_col
  logic [1:0]           out_tuser;        // vertical_pick, horizontal_pick
  logic                 out_tlast;

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int cycle_count  = 0;
  int words_sent   = 0;
  int reg_writes   = 0;
  int mismatches;
  int pending;
  int edges_checked;

  pixel_affinity_edge_min dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  pae_edge_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .mismatches    (mismatches),
    .pending       (pending),
    .edges_checked (edges_checked)
  );

  always #10 clk = ~clk;

  // watchdog, reckoned well above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d edge words outstanding", cycle_count,
               pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // output back-pressure, one fresh draw per cycle
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic set_idling(input idling_t mode);
    case (mode)
      IDLE_NONE: begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      IDLE_SENDER: begin
        send_gap_pct = 82;
        stall_pct    = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct = 0;
        stall_pct    = 82;
      end
      default: begin
        send_gap_pct = 18;
        stall_pct    = 18;
      end
    endcase
  endtask

  // keep_valid holds cfg_valid high when another write follows straight on
  task automatic write_word(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val,
                            input bit keep_valid);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    if (!keep_valid) cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_word(REG_FRAME_WIDTH, w, 1'b1);
    write_word(REG_FRAME_HEIGHT, h, 1'b0);
  endtask

  // the word stays valid on return, so the caller lowers tvalid after its last one
  task automatic send_word(input logic [15:0] sample);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // half full-range values, with a good share of extremes and near-equal values for ties
  function automatic logic [15:0] pick_sample();
    int v;
    case ($urandom_range(0, 7))
      0:       v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      1, 2, 3: v = int'($urandom_range(0, 6)) - 3;
      default: v = int'($urandom);
    endcase
    return v[15:0];
  endfunction

  task automatic send_run(input int n);
    for (int i = 0; i < n; i++) send_word(pick_sample());
    in_tvalid <= 1'b0;
  endtask

  // waits until every predicted edge word is out, then lets the pipeline drain
  task automatic settle();
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // 4x3 grid: every min/pick relation (less, tie, greater) on both edges, plus the
  // sample extremes, so each bit of the sample sees both values
  function automatic logic [15:0] grid_sample(input int idx);
    case (idx)
      0:       return 16'h0000;
      1:       return 16'h0005;
      2:       return 16'h0005;
      3:       return 16'h8000;
      4:       return 16'h8000;
      5:       return 16'h0005;
      6:       return 16'h7fff;
      7:       return 16'h0007;
      8:       return 16'h7fff;
      9:       return 16'hffff;
      10:      return 16'hffff;
      default: return 16'h0000;
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;

    set_idling(IDLE_NONE);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry is 1024x1024: a short run stays in the first row and gives no edges
    send_run(40);
    settle();

    // directed grid, then four more words that wrap into the next frame's top row
    configure(11'd4, 11'd3);
    for (int i = 0; i < 16; i++) send_word(grid_sample(i % 12));
    in_tvalid <= 1'b0;
    settle();

    // writes to unused indexes must not restart the frame: the next row still gives edges
    write_word(REG_SPARE_A, 11'h7ff, 1'b1);
    write_word(REG_SPARE_B, 11'h000, 1'b0);
    send_run(4);
    settle();

    // rewriting the width restarts at row 0, so this row must give no edges
    write_word(REG_FRAME_WIDTH, 11'd4, 1'b0);
    send_run(4);
    settle();

    // extreme sizes, reached through out-of-range values that clamp
    set_idling(IDLE_SENDER);
    configure(11'd0, 11'd2000);          // 2 wide, 1024 high
    send_run(40);
    settle();

    set_idling(IDLE_RECEIVER);
    configure(11'd1, 11'd0);             // smallest frame, 2x2
    send_run(12);
    settle();
    configure(11'd1025, 11'd2);          // width clamps to the line store size
    send_run(24);
    settle();

    // one whole wider frame, ending on tlast
    set_idling(IDLE_BOTH);
    configure(11'd40, 11'd3);
    send_run(120);
    settle();

    // random sizes and content; some phases pause mid-frame until the output drains
    for (int p = 0; p < 16; p++) begin
      set_idling(idling_t'(p % 4));
      if (p % 8 == 7) begin
        w = 11'($urandom);
        h = 11'($urandom);
      end else begin
        w = 11'($urandom_range(2, 12));
        h = 11'($urandom_range(2, 6));
      end
      if ($urandom_range(0, 3) == 0)
        write_word(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, 11'($urandom),
                   1'b1);
      configure(w, h);
      if ($urandom_range(0, 2) == 0) begin
        send_run(8);
        settle();
        send_run(8);
      end else begin
        send_run(16);
      end
      settle();
    end

    @(negedge clk);
    $display("run covered %0d sample words and %0d register writes over reset, extreme and",
             words_sent, reg_writes);
    $display("random frame sizes under four idling patterns; %0d edge words checked",
             edges_checked);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/pae_pkg.sv
rtl/pae_ram.sv
rtl/pae_front.sv
rtl/pae_queue.sv
rtl/pae_back.sv
rtl/pixel_affinity_edge_min.sv
verif/pae_edge_checker.sv
verif/tb_pixel_affinity_edge_min.sv
